// ----- design/scpa_pkg.sv -----
// Package for the polynomial sine/cosine unit: widths, coefficient tables,
// stage payload types and the per-step evaluation plan.
// No dependencies.
`default_nettype none

package scpa_pkg;

  localparam int ACC_W   = 32;
  localparam int FRAC_W  = 30;
  localparam int X_W     = FRAC_W + 1;
  localparam int SQ_W    = 2 * X_W;
  localparam int MUL_W   = ACC_W + X_W;
  localparam int PROD_W  = 48;
  localparam int HALF_W  = PROD_W / 2;
  localparam int KPI_W   = 30;
  localparam int ANG_FRAC = 16;
  localparam int NUM_VARIANTS = 6;
  localparam int NUM_STEPS = 3;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam logic [2:0] VAR_CUBIC      = 3'd0;
  localparam logic [2:0] VAR_ODD3       = 3'd1;
  localparam logic [2:0] VAR_ODD5       = 3'd2;
  localparam logic [2:0] VAR_EVEN6      = 3'd3;
  localparam logic [2:0] VAR_EVEN4      = 3'd4;
  localparam logic [2:0] VAR_EVEN2      = 3'd5;
  localparam logic [2:0] VAR_RESET      = VAR_ODD5;
  localparam logic [2:0] VAR_FIRST_EVEN = VAR_EVEN6;
  localparam logic [2:0] VAR_LAST       = VAR_EVEN2;

  localparam logic [63:0] SCALE_Q30 = 64'd1073741824;
  localparam logic [63:0] DEC       = 64'd1000000000;
  localparam logic [63:0] HALF_DEC  = 64'd500000000;

  localparam logic [KPI_W-1:0] TWO_OVER_PI =
    KPI_W'((64'd636619772 * SCALE_Q30 + HALF_DEC) / DEC);

  localparam logic [X_W-1:0] ONE_X = X_W'(1) << FRAC_W;
  localparam logic [FRAC_W-1:0] ROUND_Q30 = FRAC_W'(1) << (FRAC_W - 1);
  localparam acc_t ONE_Q30 = acc_t'(SCALE_Q30);

  localparam acc_t K0_0 = -acc_t'((64'd436048920 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K0_1 = -acc_t'((64'd174419790 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K0_2 = acc_t'((64'd1610468700 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K0_3 = -acc_t'((64'd1367079 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K1_0 = -acc_t'((64'd552557921 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K1_1 = acc_t'((64'd1548066186 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K2_0 = acc_t'((64'd71860854 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K2_1 = -acc_t'((64'd642113167 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K2_2 = acc_t'((64'd1570320019 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K3_0 = -acc_t'((64'd19095735 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K3_1 = acc_t'((64'd252580239 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K3_2 = -acc_t'((64'd1233484504 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K3_3 = acc_t'((64'd999993295 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K4_0 = acc_t'((64'd223990274 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K4_1 = -acc_t'((64'd1222796733 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K4_2 = acc_t'((64'd999403229 * SCALE_Q30 + HALF_DEC) / DEC);
  localparam acc_t K5_0 = acc_t'((64'd971995202 * SCALE_Q30 + HALF_DEC) / DEC);

  // multiplier operand of one Horner step; X_ONE multiplies by one, so with a zero coefficient the step passes through
  typedef enum logic [1:0] {
    X_T,
    X_SQ,
    X_ONE
  } x_sel_t;

  typedef struct packed {
    x_sel_t xsel;
    acc_t   coef;
  } step_t;

  typedef struct packed {
    logic mul;
    logic add;
  } step_en_t;

  // lane 0 evaluates at f, lane 1 at 1-f
  typedef struct packed {
    logic [1:0][X_W-1:0] t;
    logic [1:0][X_W-1:0] t2;
    logic [1:0]          quad;
    logic                neg;
  } side_t;

  localparam acc_t INIT_COEF [NUM_VARIANTS] = '{
    K0_0, K1_0, K2_0, K3_0, K4_0, -ONE_Q30
  };

  localparam acc_t STEP_COEF [NUM_VARIANTS][NUM_STEPS] = '{
    '{K0_1, K0_2, K0_3},
    '{K1_1, acc_t'(0), acc_t'(0)},
    '{K2_1, K2_2, acc_t'(0)},
    '{K3_1, K3_2, K3_3},
    '{K4_1, K4_2, acc_t'(0)},
    '{K5_0, acc_t'(0), acc_t'(0)}
  };

  localparam x_sel_t STEP_XSEL [NUM_VARIANTS][NUM_STEPS] = '{
    '{X_T,  X_T,   X_T},
    '{X_SQ, X_T,   X_ONE},
    '{X_SQ, X_SQ,  X_T},
    '{X_SQ, X_SQ,  X_SQ},
    '{X_SQ, X_SQ,  X_ONE},
    '{X_SQ, X_ONE, X_ONE}
  };

  function automatic acc_t init_coef(input logic [2:0] variant);
    acc_t v;
    if (variant <= VAR_LAST) begin
      v = INIT_COEF[variant];
    end else begin
      v = '0;
    end
    return v;
  endfunction

  function automatic step_t step_plan(input logic [2:0] variant, input logic [1:0] idx);
    step_t p;
    if (variant <= VAR_LAST && idx < 2'(NUM_STEPS)) begin
      p.xsel = STEP_XSEL[variant][idx];
      p.coef = STEP_COEF[variant][idx];
    end else begin
      p.xsel = X_ONE;
      p.coef = '0;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- design/scpa_step.sv -----
// One Horner step for both lanes: a multiply stage and a round/add stage.
// Depends on scpa_pkg.
`default_nettype none

module scpa_step (
  input  logic               clk,
  input  scpa_pkg::step_en_t en,
  input  scpa_pkg::step_t    plan,
  input  scpa_pkg::side_t    side_in,
  input  scpa_pkg::acc_t     acc_in [2],
  output scpa_pkg::side_t    side_out,
  output scpa_pkg::acc_t     acc_out [2]
);

  logic [scpa_pkg::X_W-1:0]   x [2];
  logic [scpa_pkg::ACC_W-1:0] mag [2];
  logic [scpa_pkg::MUL_W-1:0] prod_next [2];
  logic [scpa_pkg::MUL_W-1:0] prod [2];
  logic [scpa_pkg::MUL_W-1:0] rnd [2];
  scpa_pkg::acc_t             r [2];
  logic [1:0]                 sgn;
  scpa_pkg::side_t            side_m;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      unique case (plan.xsel)
        scpa_pkg::X_T:   x[l] = side_in.t[l];
        scpa_pkg::X_SQ:  x[l] = side_in.t2[l];
        scpa_pkg::X_ONE: x[l] = scpa_pkg::ONE_X;
        default:         x[l] = scpa_pkg::ONE_X;
      endcase
      mag[l] = acc_in[l][scpa_pkg::ACC_W-1] ? scpa_pkg::ACC_W'(-acc_in[l])
                                            : scpa_pkg::ACC_W'(acc_in[l]);
      prod_next[l] = scpa_pkg::MUL_W'(mag[l]) * scpa_pkg::MUL_W'(x[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int l = 0; l < 2; l++) begin
        prod[l] <= prod_next[l];
        sgn[l]  <= acc_in[l][scpa_pkg::ACC_W-1];
      end
      side_m <= side_in;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd[l] = prod[l] + scpa_pkg::MUL_W'(scpa_pkg::ROUND_Q30);
      r[l]   = rnd[l][scpa_pkg::FRAC_W +: scpa_pkg::ACC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.add) begin
      for (int l = 0; l < 2; l++) begin
        acc_out[l] <= (sgn[l] ? -r[l] : r[l]) + plan.coef;
      end
      side_out <= side_m;
    end
  end

endmodule

`default_nettype wire

// ----- design/sine_cosine_poly_approx.sv -----
// Top level of the polynomial sine/cosine unit.
// Depends on scpa_pkg and scpa_step.
//
// Usage:
//   Input channel in_valid/in_stall carries angle (radians, signed, 16
//   fraction bits). Output channel out_valid/out_stall carries sine_value and
//   cosine_value (signed, RESULT_WIDTH-2 fraction bits). A transaction moves
//   at a clock edge with valid high and stall low.
//   cfg_we/cfg_wdata write the variant register (polynomial choice); write it
//   only while no transaction is in flight. Codes 6 and 7 give zero results.
//   Pipeline: one register stage each for magnitude, 2/pi partial
//   products, quadrant split, square product, square rounding, two stages
//   per Horner step (three steps) and the output register.
//   Throughput: one transaction per cycle while out_stall is low, set by
//   the fully pipelined multipliers (two 24x30 for the reduction, two 32x31
//   per Horner step).
//   Reset (rst, synchronous) empties the pipeline and sets variant to 2.
//   When out_stall is high the output holds; stages behind it keep filling
//   empty slots, and in_stall rises only when every stage holds a transaction.
`default_nettype none

module sine_cosine_poly_approx #(
  parameter int ANGLE_WIDTH  = 32,
  parameter int RESULT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ANGLE_WIDTH-1:0]  angle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [RESULT_WIDTH-1:0] sine_value,
  output logic signed [RESULT_WIDTH-1:0] cosine_value
);

  localparam int NS       = 12;
  localparam int ST_MAG   = 0;
  localparam int ST_PP    = 1;
  localparam int ST_T     = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_T2    = 4;
  localparam int ST_STEP  = 5;
  localparam int ST_OUT   = NS - 1;

  localparam int CONV_W   = RESULT_WIDTH + scpa_pkg::ACC_W + 1;
  localparam int CONV_SHR = (RESULT_WIDTH < 32) ? 32 - RESULT_WIDTH : 0;
  localparam int CONV_SHL = (RESULT_WIDTH > 32) ? RESULT_WIDTH - 32 : 0;
  localparam logic [CONV_W-1:0] CONV_RND = (CONV_W'(1) << CONV_SHR) >> 1;
  localparam logic [CONV_W-1:0] CONV_MAX = (CONV_W'(1) << (RESULT_WIDTH - 1)) - CONV_W'(1);

  logic [2:0]    variant;
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_in;
  logic [NS-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= scpa_pkg::VAR_RESET;
    end else if (cfg_we) begin
      variant <= cfg_wdata;
    end
  end

  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign vld_in    = {vld[NS-2:0], in_valid};
  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // magnitude
  logic [ANGLE_WIDTH-1:0] angle_u;
  logic [ANGLE_WIDTH-1:0] mag;
  logic                   neg0;

  assign angle_u = angle;

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      mag  <= angle_u[ANGLE_WIDTH-1] ? ~angle_u + 1'b1 : angle_u;
      neg0 <= angle_u[ANGLE_WIDTH-1];
    end
  end

  // partial products of magnitude times 2/pi, kept modulo 2^48
  localparam int PP_W = scpa_pkg::HALF_W + scpa_pkg::KPI_W;

  logic [scpa_pkg::PROD_W-1:0] mag48;
  logic [PP_W-1:0]             pl_next;
  logic [PP_W-1:0]             ph_next;
  logic [PP_W-1:0]             pp_lo;
  logic [scpa_pkg::HALF_W-1:0] pp_hi;
  logic                        neg1;

  assign mag48   = scpa_pkg::PROD_W'(mag);
  assign pl_next = PP_W'(mag48[scpa_pkg::HALF_W-1:0]) * PP_W'(scpa_pkg::TWO_OVER_PI);
  assign ph_next = PP_W'(mag48[scpa_pkg::PROD_W-1:scpa_pkg::HALF_W])
                 * PP_W'(scpa_pkg::TWO_OVER_PI);

  always_ff @(posedge clk) begin
    if (en[ST_PP]) begin
      pp_lo <= pl_next;
      pp_hi <= ph_next[scpa_pkg::HALF_W-1:0];
      neg1  <= neg0;
    end
  end

  // quadrant and fraction
  logic [scpa_pkg::PROD_W-1:0] prod;
  logic [scpa_pkg::FRAC_W-1:0] frac;
  scpa_pkg::side_t             side2_next;
  scpa_pkg::side_t             side2;

  always_comb begin
    prod = scpa_pkg::PROD_W'(pp_lo) + {pp_hi, scpa_pkg::HALF_W'(0)};
    frac = prod[scpa_pkg::ANG_FRAC +: scpa_pkg::FRAC_W];
    side2_next.t[0] = scpa_pkg::X_W'(frac);
    side2_next.t[1] = scpa_pkg::ONE_X - scpa_pkg::X_W'(frac);
    side2_next.t2   = '0;
    side2_next.quad = prod[scpa_pkg::ANG_FRAC + scpa_pkg::FRAC_W +: 2];
    side2_next.neg  = neg1;
  end

  always_ff @(posedge clk) begin
    if (en[ST_T]) begin
      side2 <= side2_next;
    end
  end

  // square of both arguments
  logic [scpa_pkg::SQ_W-1:0] sq [2];
  logic [scpa_pkg::SQ_W-1:0] sq_rnd [2];
  scpa_pkg::side_t           side3;
  scpa_pkg::side_t           side4_next;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int l = 0; l < 2; l++) begin
        sq[l] <= scpa_pkg::SQ_W'(side2.t[l]) * scpa_pkg::SQ_W'(side2.t[l]);
      end
      side3 <= side2;
    end
  end

  always_comb begin
    side4_next = side3;
    for (int l = 0; l < 2; l++) begin
      sq_rnd[l]        = sq[l] + scpa_pkg::SQ_W'(scpa_pkg::ROUND_Q30);
      side4_next.t2[l] = sq_rnd[l][scpa_pkg::FRAC_W +: scpa_pkg::X_W];
    end
  end

  scpa_pkg::side_t side_c [scpa_pkg::NUM_STEPS+1];
  scpa_pkg::acc_t  acc_c  [scpa_pkg::NUM_STEPS+1][2];
  scpa_pkg::step_t plan   [scpa_pkg::NUM_STEPS];

  always_ff @(posedge clk) begin
    if (en[ST_T2]) begin
      side_c[0]   <= side4_next;
      acc_c[0][0] <= scpa_pkg::init_coef(variant);
      acc_c[0][1] <= scpa_pkg::init_coef(variant);
    end
  end

  // Horner steps
  for (genvar s = 0; s < scpa_pkg::NUM_STEPS; s++) begin : g_step
    scpa_pkg::step_en_t step_en;

    assign plan[s]      = scpa_pkg::step_plan(variant, 2'(s));
    assign step_en.mul  = en[ST_STEP + 2*s];
    assign step_en.add  = en[ST_STEP + 2*s + 1];

    scpa_step u_step (
      .clk      (clk),
      .en       (step_en),
      .plan     (plan[s]),
      .side_in  (side_c[s]),
      .acc_in   (acc_c[s]),
      .side_out (side_c[s+1]),
      .acc_out  (acc_c[s+1])
    );
  end

  // quadrant fold, sign and output scaling
  function automatic logic [RESULT_WIDTH-1:0] to_field(input scpa_pkg::acc_t v,
                                                       input logic flip);
    logic                       neg;
    logic [scpa_pkg::ACC_W-1:0] vmag;
    logic [CONV_W-1:0]          m;
    logic [RESULT_WIDTH-1:0]    r;
    neg  = v[scpa_pkg::ACC_W-1] ^ flip;
    vmag = v[scpa_pkg::ACC_W-1] ? scpa_pkg::ACC_W'(-v) : scpa_pkg::ACC_W'(v);
    m    = ((CONV_W'(vmag) + CONV_RND) >> CONV_SHR) << CONV_SHL;
    if (m > CONV_MAX) begin
      m = CONV_MAX + CONV_W'(neg);
    end
    r = RESULT_WIDTH'(m);
    return neg ? -r : r;
  endfunction

  scpa_pkg::side_t side_f;
  scpa_pkg::acc_t  val_s;
  scpa_pkg::acc_t  val_c;
  logic            cos_like;
  logic            swap;
  logic            s_flip;
  logic            c_flip;
  logic [RESULT_WIDTH-1:0] sine_next;
  logic [RESULT_WIDTH-1:0] cosine_next;

  always_comb begin
    side_f   = side_c[scpa_pkg::NUM_STEPS];
    cos_like = variant >= scpa_pkg::VAR_FIRST_EVEN;
    swap     = side_f.quad[0] ^ cos_like;
    val_s    = swap ? acc_c[scpa_pkg::NUM_STEPS][1] : acc_c[scpa_pkg::NUM_STEPS][0];
    val_c    = swap ? acc_c[scpa_pkg::NUM_STEPS][0] : acc_c[scpa_pkg::NUM_STEPS][1];
    s_flip   = side_f.quad[1] ^ side_f.neg;
    c_flip   = side_f.quad[1] ^ side_f.quad[0];
    if (variant > scpa_pkg::VAR_LAST) begin
      sine_next   = '0;
      cosine_next = '0;
    end else begin
      sine_next   = to_field(val_s, s_flip);
      cosine_next = to_field(val_c, c_flip);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      sine_value   <= sine_next;
      cosine_value <= cosine_next;
    end
  end

endmodule

`default_nettype wire
